>>> src/deq_pkg.sv
package deq_pkg;

  localparam int unsigned REC_W       = 64;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned TOTAL_W     = 6;
  localparam int unsigned MAX_RESULTS = 32;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_REAR  = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_REAR  = 3'd3,
    ACT_LIST      = 3'd4
  } deq_action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } deq_status_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [REC_W-1:0] record_in;
  } deq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [REC_W-1:0]   record_out;
    logic [POS_W-1:0]   position;
    logic [TOTAL_W-1:0] entry_total;
    logic               last;
  } deq_rsp_t;

endpackage

>>> src/deq_ram.sv
module deq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/double_ended_queue_core.sv
// double-ended queue of record words kept in a ring buffer in one sync ram
//
// command channel: req is taken at a rising edge where start is high and busy
// is low. req.action picks insert front, insert rear, delete front, delete rear
// or list; codes above list are taken and ignored, with no result beat.
// result channel: each result beat sits on rsp for one cycle, marked by done.
// the receiver cannot stall, so every beat must be captured when done is high.
//
// result beats: an insert or delete gives its single beat in the cycle after the
// command edge; busy stays low, so one insert or delete is taken every cycle.
// list of n held records (n capped at 32) gives n beats on consecutive
// cycles starting the cycle after the command edge, rsp.last on the final one;
// busy is high during the walk, since the ram's single read port delivers one
// record per cycle. an empty list or delete gives one beat with status empty;
// an insert into a full queue gives status full and drops the record.
//
// reset (rst, synchronous) empties the queue: head, tail and count go to zero.
// ram contents are left as they are; only slots inside the held span are read.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH        = 32,
  parameter int unsigned RECORD_WIDTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  deq_req_t req,
  output logic     busy,
  output logic     done,
  output deq_rsp_t rsp
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned MAX_N = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
  localparam int unsigned NW    = $clog2(MAX_N + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - 1'b1);
  endfunction

  // control state
  state_t           state, state_next;
  logic [IDX_W-1:0] head, head_next;        // slot of the front record
  logic [IDX_W-1:0] tail, tail_next;        // slot one past the rear record
  logic [CNT_W-1:0] occ, occ_next;

  // list walk
  logic [IDX_W-1:0] walk_slot, walk_slot_next;
  logic [NW-1:0]    walk_pos, walk_pos_next;
  logic [NW-1:0]    walk_lim, walk_lim_next;

  // result stage
  logic             done_next;
  logic [1:0]       out_status, status_next;
  logic [NW-1:0]    out_pos, pos_next;
  logic [CNT_W-1:0] out_total, total_next;
  logic             out_last, last_next;
  logic             out_rd, rd_next;        // record comes from the ram read

  // ram port
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [RECORD_WIDTH-1:0] ram_wdata, ram_rdata;

  logic          accept;
  logic          full, empty;
  logic [NW-1:0] lim_c;

  assign accept = start && !busy;
  assign busy   = (state == ST_LIST);
  assign full   = (occ == CNT_W'(DEPTH));
  assign empty  = (occ == '0);
  assign lim_c  = (occ > CNT_W'(MAX_N)) ? NW'(MAX_N) : NW'(occ);

  // a command either writes or reads, each at its own command edge, and the walk's
  // reads come while busy holds off writes, so a read never meets a write to the same slot in one cycle
  deq_ram #(
    .WIDTH (RECORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    occ_next       = occ;
    walk_slot_next = walk_slot;
    walk_pos_next  = walk_pos;
    walk_lim_next  = walk_lim;

    ram_we    = 1'b0;
    ram_waddr = wrap_dec(head);
    ram_wdata = req.record_in[RECORD_WIDTH-1:0];   // record masked to store width
    ram_re    = 1'b0;
    ram_raddr = head;

    done_next   = 1'b0;
    status_next = STAT_OK;
    pos_next    = '0;
    total_next  = occ;
    last_next   = 1'b1;
    rd_next     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.action)
            ACT_INS_FRONT: begin
              done_next = 1'b1;
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = wrap_dec(head);
                head_next  = wrap_dec(head);
                occ_next   = CNT_W'(occ + 1'b1);
                total_next = CNT_W'(occ + 1'b1);
              end
            end
            ACT_INS_REAR: begin
              done_next = 1'b1;
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = tail;
                tail_next  = wrap_inc(tail);
                occ_next   = CNT_W'(occ + 1'b1);
                total_next = CNT_W'(occ + 1'b1);
              end
            end
            ACT_DEL_FRONT: begin
              done_next = 1'b1;
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = head;
                rd_next    = 1'b1;
                head_next  = wrap_inc(head);
                occ_next   = CNT_W'(occ - 1'b1);
                total_next = CNT_W'(occ - 1'b1);
              end
            end
            ACT_DEL_REAR: begin
              done_next = 1'b1;
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = wrap_dec(tail);
                rd_next    = 1'b1;
                tail_next  = wrap_dec(tail);
                occ_next   = CNT_W'(occ - 1'b1);
                total_next = CNT_W'(occ - 1'b1);
              end
            end
            ACT_LIST: begin
              done_next = 1'b1;
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                // first entry read right away, the walk covers the rest
                ram_re         = 1'b1;
                ram_raddr      = head;
                rd_next        = 1'b1;
                last_next      = (lim_c == NW'(1));
                walk_slot_next = wrap_inc(head);
                walk_pos_next  = NW'(1);
                walk_lim_next  = lim_c;
                if (lim_c != NW'(1)) begin
                  state_next = ST_LIST;
                end
              end
            end
            default: begin
              // unused action code: no beat, no change
            end
          endcase
        end
      end
      ST_LIST: begin
        ram_re         = 1'b1;
        ram_raddr      = walk_slot;
        rd_next        = 1'b1;
        done_next      = 1'b1;
        pos_next       = walk_pos;
        last_next      = (NW'(walk_pos + 1'b1) == walk_lim);
        walk_pos_next  = NW'(walk_pos + 1'b1);
        walk_slot_next = wrap_inc(walk_slot);
        if (NW'(walk_pos + 1'b1) == walk_lim) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      occ   <= occ_next;
      done  <= done_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    walk_slot  <= walk_slot_next;
    walk_pos   <= walk_pos_next;
    walk_lim   <= walk_lim_next;
    out_status <= status_next;
    out_pos    <= pos_next;
    out_total  <= total_next;
    out_last   <= last_next;
    out_rd     <= rd_next;
  end

  // the ram's registered read data lines up with the result stage
  always_comb begin
    rsp.status      = out_status;
    rsp.record_out  = out_rd ? REC_W'(ram_rdata) : '0;
    rsp.position    = POS_W'(out_pos);
    rsp.entry_total = TOTAL_W'(out_total);
    rsp.last        = out_last;
  end

  // count never passes capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(DEPTH))
    else $error("occupancy above capacity");

  // an accepted insert or delete gives its beat in the next cycle
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    accept && (req.action == ACT_INS_FRONT || req.action == ACT_INS_REAR ||
               req.action == ACT_DEL_FRONT || req.action == ACT_DEL_REAR)
    |=> done && rsp.last)
    else $error("insert or delete beat missing");

  // the walk puts out one beat per cycle
  a_list_beat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIST) |=> done)
    else $error("list walk skipped a beat");

  // pointers and count hold still during a walk
  a_list_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIST) |=> $stable(occ) && $stable(head) && $stable(tail))
    else $error("queue changed during list");

endmodule
